>>> rtl/core/vpfa_pkg.sv
// Package for the video packet frame assembler: geometry constants, codes,
// capture state type and the structs passed between the front and back parts.
// No dependencies.
package vpfa_pkg;

    localparam int LINE_PIXELS  = 80;
    localparam int FRAME_LINES  = 60;
    localparam int HEADER_BYTES = 4;
    localparam int PKT_BYTES    = HEADER_BYTES + 2 * LINE_PIXELS;

    localparam int POS_W   = $clog2(PKT_BYTES);
    localparam int LINE_W  = (FRAME_LINES > 1) ? $clog2(FRAME_LINES) : 1;
    localparam int ADDR_W  = 13;
    localparam int LINES_W = 6;
    localparam int CNT_W   = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

    localparam logic [3:0]  NIBBLE_MASK   = 4'hF;
    localparam logic [11:0] LINE_MASK     = 12'hFFF;
    localparam logic [15:0] RAW14_MASK    = 16'h3FFF;
    localparam logic [15:0] DEFAULT_LIMIT = 16'd5000;
    localparam logic [15:0] CNT_MAX       = 16'hFFFF;

    // config register indexes
    localparam logic CFG_LINEAR = 1'b0;
    localparam logic CFG_LIMIT  = 1'b1;

    // input request kinds
    localparam logic REQ_DATA  = 1'b0;
    localparam logic REQ_BEGIN = 1'b1;

    // frame status codes
    localparam logic [1:0] STAT_CAPTURING = 2'd0;
    localparam logic [1:0] STAT_COMPLETE  = 2'd1;
    localparam logic [1:0] STAT_TIMEOUT   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CAPTURE,
        ST_DONE,
        ST_TIMEOUT
    } t_cap_state;

    // parser to tracker, one per accepted data byte
    typedef struct packed {
        logic              write;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       value;
        logic              last;
        logic              discard;
        logic              line_ok;
        logic [LINE_W-1:0] line;
    } t_pkt_evt;

    // one result beat as held in the queue
    typedef struct packed {
        logic               pixel_write;
        logic [ADDR_W-1:0]  pixel_address;
        logic [15:0]        pixel_value;
        logic               packet_end;
        logic [1:0]         frame_status;
        logic [LINES_W-1:0] lines_received;
        logic [CNT_W-1:0]   discarded_packets;
    } t_result;

endpackage

>>> rtl/core/vpfa_parser.sv
// Front part, byte parser: packet position, header decode, pixel assembly.
// Depends on vpfa_pkg.
module vpfa_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_begin,
    input  logic               i_byte_en,
    input  logic [7:0]         i_byte,
    input  logic               i_linear,
    output vpfa_pkg::t_pkt_evt o_evt
);
    import vpfa_pkg::*;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [7:0]        r_hdr_hi;
    logic [7:0]        r_hold;
    logic              r_line_ok;
    logic              r_discard;
    logic [LINE_W-1:0] r_line;
    logic [ADDR_W-1:0] r_base;

    logic [11:0]       line12;
    logic              hdr_discard;
    logic              is_last;
    logic              in_body;
    logic [POS_W-1:0]  k;
    logic [15:0]       raw;

    assign line12      = {r_hdr_hi[3:0], i_byte} & LINE_MASK;
    assign hdr_discard = (r_hdr_hi[3:0] & NIBBLE_MASK) == NIBBLE_MASK;
    assign is_last     = r_pos == POS_W'(PKT_BYTES - 1);
    assign in_body     = r_pos >= POS_W'(HEADER_BYTES);
    assign k           = r_pos - POS_W'(HEADER_BYTES);
    assign raw         = {r_hold, i_byte};
    assign n_pos       = is_last ? '0 : r_pos + 1'b1;

    always_comb begin
        o_evt.write   = i_byte_en && in_body && k[0] && r_line_ok;
        o_evt.addr    = r_base + ADDR_W'(k[POS_W-1:1]);
        o_evt.value   = i_linear ? raw : (raw & RAW14_MASK);
        o_evt.last    = i_byte_en && is_last;
        o_evt.discard = r_discard;
        o_evt.line_ok = r_line_ok;
        o_evt.line    = r_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_begin) begin
            r_pos <= '0;
        end else if (i_byte_en) begin
            r_pos <= n_pos;
        end
    end

    // header and pixel payload
    always_ff @(posedge i_clk) begin
        if (i_byte_en) begin
            if (r_pos == '0) begin
                r_hdr_hi <= i_byte;
            end
            if (r_pos == POS_W'(1)) begin
                r_discard <= hdr_discard;
                r_line_ok <= !hdr_discard && (line12 < 12'(FRAME_LINES));
                r_line    <= line12[LINE_W-1:0];
                r_base    <= ADDR_W'(line12[LINE_W-1:0]) * ADDR_W'(LINE_PIXELS);
            end
            if (in_body && !k[0]) begin
                r_hold <= i_byte;
            end
        end
    end

    pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < POS_W'(PKT_BYTES))
        else $error("packet position beyond packet length");

endmodule

>>> rtl/core/vpfa_tracker.sv
// Front part, capture tracker: seen-line map, counters, capture state and
// result assembly. Depends on vpfa_pkg.
module vpfa_tracker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_begin,
    input  vpfa_pkg::t_pkt_evt i_evt,
    input  logic [15:0]        i_limit,
    output logic               o_capturing,
    output logic               o_push,
    output vpfa_pkg::t_result  o_res
);
    import vpfa_pkg::*;

    t_cap_state             r_state, n_state;
    logic [FRAME_LINES-1:0] r_map, n_map;
    logic [LINES_W-1:0]     r_lines, n_lines;
    logic [CNT_W-1:0]       r_att, n_att;
    logic [CNT_W-1:0]       r_disc, n_disc;
    logic                   new_line;

    assign new_line    = i_evt.line_ok && !r_map[i_evt.line];
    assign o_capturing = r_state == ST_CAPTURE;

    // counters and map
    always_comb begin
        n_map   = r_map;
        n_lines = r_lines;
        n_att   = r_att;
        n_disc  = r_disc;
        if (i_begin) begin
            n_map   = '0;
            n_lines = '0;
            n_att   = '0;
            n_disc  = '0;
        end else if (i_evt.last) begin
            if (r_att != CNT_MAX) n_att = r_att + 1'b1;
            if (i_evt.discard) begin
                if (r_disc != CNT_MAX) n_disc = r_disc + 1'b1;
            end else if (new_line) begin
                n_map[i_evt.line] = 1'b1;
                n_lines           = r_lines + 1'b1;
            end
        end
    end

    // next state; completion wins over timeout
    always_comb begin
        n_state = r_state;
        priority if (i_begin) begin
            n_state = ST_CAPTURE;
        end else if (i_evt.last) begin
            priority if (n_lines >= LINES_W'(FRAME_LINES)) n_state = ST_DONE;
            else if (n_att >= i_limit)                    n_state = ST_TIMEOUT;
            else                                          n_state = ST_CAPTURE;
        end else begin
            n_state = r_state;
        end
    end

    // result beat, reports counts after this byte
    always_comb begin
        o_push                  = i_evt.write || i_evt.last;
        o_res.pixel_write       = i_evt.write;
        o_res.pixel_address     = i_evt.write ? i_evt.addr : '0;
        o_res.pixel_value       = i_evt.write ? i_evt.value : '0;
        o_res.packet_end        = i_evt.last;
        o_res.lines_received    = n_lines;
        o_res.discarded_packets = n_disc;
        unique case (n_state)
            ST_DONE:    o_res.frame_status = STAT_COMPLETE;
            ST_TIMEOUT: o_res.frame_status = STAT_TIMEOUT;
            default:    o_res.frame_status = STAT_CAPTURING;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_map   <= '0;
            r_lines <= '0;
            r_att   <= '0;
            r_disc  <= '0;
        end else begin
            r_state <= n_state;
            r_map   <= n_map;
            r_lines <= n_lines;
            r_att   <= n_att;
            r_disc  <= n_disc;
        end
    end

    map_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_map) == int'(r_lines))
        else $error("seen-line map and line count disagree");

    done_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_lines == LINES_W'(FRAME_LINES)))
        else $error("frame complete without all lines");

endmodule

>>> rtl/core/vpfa_queue.sv
// Back part: short result queue decoupling the parser from the output stall.
// Depends on vpfa_pkg.
module vpfa_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vpfa_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output logic              o_full,
    output vpfa_pkg::t_result o_data
);
    import vpfa_pkg::*;

    t_result           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count;
    logic              do_push, do_pop;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("result pushed into a full queue");

endmodule

>>> rtl/core/video_packet_frame_assembler.sv
// Top level of the video packet frame assembler: config registers, byte
// parser and capture tracker (front), result queue (back).
// Depends on vpfa_pkg, vpfa_parser, vpfa_tracker, vpfa_queue.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tuser: req_type; tdata: data_byte
//  m_*       out  m_tvalid/m_tready    tuser: pixel_write; tlast: packet_end;
//                                      tdata: address, value, status, lines, discards
//  i_cfg_*   in   i_cfg_we             index 0 linear_temp_mode, 1 packet_limit
//
// One byte a cycle if s_tready: parser and tracker settle each byte combinationally,
// and any result is written into a four-beat queue at the edge that takes the byte.
// m_tvalid rises straight after that edge, from the registered queue count.
// s_tready drops only while the queue is full, so output stalls reach the input
// after four beats of backlog.
// Synchronous active-low reset: idle, no capture, limit 5000, 14-bit mode.
module video_packet_frame_assembler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [12:0] pixel_address, [28:13] pixel_value,
                                   // [30:29] frame_status, [36:31] lines_received,
                                   // [52:37] discarded_packets, [55:53] zero
    output logic        m_tuser,   // [0] pixel_write
    output logic        m_tlast,   // packet_end
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);
    import vpfa_pkg::*;

    logic        r_linear;
    logic [15:0] r_limit;

    logic        full;
    logic        capturing;
    logic        in_acc;
    logic        begin_en;
    logic        byte_en;
    logic        push;
    t_pkt_evt    evt;
    t_result     res;
    t_result     head;

    assign s_tready = !full;
    assign in_acc   = s_tvalid && s_tready;
    assign begin_en = in_acc && (s_tuser == REQ_BEGIN);
    // data bytes outside a capture are dropped here
    assign byte_en  = in_acc && (s_tuser == REQ_DATA) && capturing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear <= 1'b0;
            r_limit  <= DEFAULT_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LINEAR: r_linear <= i_cfg_wdata[0];
                CFG_LIMIT:  r_limit  <= i_cfg_wdata;
            endcase
        end
    end

    vpfa_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_begin   (begin_en),
        .i_byte_en (byte_en),
        .i_byte    (s_tdata),
        .i_linear  (r_linear),
        .o_evt     (evt)
    );

    vpfa_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_begin     (begin_en),
        .i_evt       (evt),
        .i_limit     (r_limit),
        .o_capturing (capturing),
        .o_push      (push),
        .o_res       (res)
    );

    vpfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .i_pop   (m_tready),
        .o_valid (m_tvalid),
        .o_full  (full),
        .o_data  (head)
    );

    assign m_tuser = head.pixel_write;
    assign m_tlast = head.packet_end;
    assign m_tdata = {3'b000, head.discarded_packets, head.lines_received,
                      head.frame_status, head.pixel_value, head.pixel_address};

endmodule

>>> tb/video_packet_frame_assembler_test.sv
// Self-checking testbench for video_packet_frame_assembler: byte stream in,
// pixel writes and capture status out, predicted beat by beat in the bench.
// Depends on vpfa_pkg and the RTL of the block; nothing else.
module video_packet_frame_assembler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vpfa_pkg::*;

    localparam int HOLDOFF_CYCLES = 300;   // long receiver stall, fills the result queue
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake or write
    localparam int SETTLE_CYCLES  = 4;     // quiet wait once all owed beats are back
    localparam int RANDOM_PACKETS = 4;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;   // [7:0] data_byte
    logic        s_tuser     = 1'b0;    // [0] req_type
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [55:0] m_tdata;               // [12:0] pixel_address, [28:13] pixel_value,
                                        // [30:29] frame_status, [36:31] lines_received,
                                        // [52:37] discarded_packets, [55:53] zero
    logic        m_tuser;               // [0] pixel_write
    logic        m_tlast;               // packet_end
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_wdata = 16'h0000;

    video_packet_frame_assembler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench copy of the assembler state, as after reset
    // ------------------------------------------------------------------
    logic                   cfg_linear    = 1'b0;
    logic [15:0]            cfg_limit     = DEFAULT_LIMIT;
    int                     cur_pos       = 0;
    logic [15:0]            hdr_word      = 16'h0000;
    logic [7:0]             pix_hi        = 8'h00;
    logic [FRAME_LINES-1:0] seen_lines    = '0;
    int                     line_count    = 0;
    logic [15:0]            packet_count  = 16'h0000;
    logic [15:0]            discard_count = 16'h0000;
    t_cap_state             capture       = ST_IDLE;

    t_result pixel_results_due[$];   // beats still owed by the block, oldest first
    t_result due;
    int      errors = 0;

    // idle-side knobs for the sender and the receiver
    bit tx_gaps = 1'b1;
    bit rx_stalls = 1'b1;
    int holdoff_request = 0;
    int stall_left = 0;

    // Mostly back to back, some short gaps, the odd long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Works out what one accepted input beat makes the block emit.
    // Header check is made once the second byte is in; counters and the seen
    // map move only on the last byte, so pixel beats before it carry old counts.
    task automatic assemble_byte(input logic req, input logic [7:0] b);
        int      pos;
        int      line;
        int      k;
        logic    discard;
        logic    line_ok;
        logic    wrote;
        logic    last;
        logic [15:0] raw;
        t_result r;

        if (req == REQ_BEGIN) begin
            // restart from anywhere, even mid-packet
            cur_pos       = 0;
            hdr_word      = 16'h0000;
            pix_hi        = 8'h00;
            seen_lines    = '0;
            line_count    = 0;
            packet_count  = 16'h0000;
            discard_count = 16'h0000;
            capture       = ST_CAPTURE;
            return;
        end
        if (capture != ST_CAPTURE) return;   // idle, complete or timed out

        pos = cur_pos;
        if (pos == 0) hdr_word = {b, 8'h00};
        else if (pos == 1) hdr_word[7:0] = b;

        discard = (hdr_word[11:8] == NIBBLE_MASK);
        line    = int'(hdr_word[11:0] & LINE_MASK);
        line_ok = !discard && (line < FRAME_LINES);

        r     = '0;
        wrote = 1'b0;
        if (pos >= HEADER_BYTES) begin
            k = pos - HEADER_BYTES;
            if (k % 2 == 0) begin
                pix_hi = b;
            end else if (line_ok) begin
                raw             = {pix_hi, b};
                wrote           = 1'b1;
                r.pixel_write   = 1'b1;
                r.pixel_address = ADDR_W'(line * LINE_PIXELS + k / 2);
                r.pixel_value   = cfg_linear ? raw : (raw & RAW14_MASK);
            end
        end

        last = (pos + 1 >= PKT_BYTES);
        if (last) begin
            cur_pos = 0;
            if (packet_count != CNT_MAX) packet_count++;
            if (discard) begin
                if (discard_count != CNT_MAX) discard_count++;
            end else if (line_ok && !seen_lines[line]) begin
                seen_lines[line] = 1'b1;
                line_count++;
            end
            // completion wins over timeout on the same packet
            if (line_count >= FRAME_LINES) capture = ST_DONE;
            else if (packet_count >= cfg_limit) capture = ST_TIMEOUT;
        end else begin
            cur_pos = pos + 1;
        end

        if (!wrote && !last) return;
        r.packet_end        = last;
        r.frame_status      = (capture == ST_DONE)    ? STAT_COMPLETE :
                              (capture == ST_TIMEOUT) ? STAT_TIMEOUT  : STAT_CAPTURING;
        r.lines_received    = LINES_W'(line_count);
        r.discarded_packets = discard_count;
        pixel_results_due.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // One input beat; s_tvalid is left high so the next beat can follow
    // straight on. Anything else that follows must drop it first.
    task automatic send_beat(input logic req, input logic [7:0] b);
        int gap;
        gap = tx_gaps ? idle_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        assemble_byte(req, b);
    endtask

    // Packet positions first .. first+count-1. With corners set, the first four
    // pixels are all ones, top two bits only (plus bit 0), zero and 14-bit max.
    task automatic send_packet_bytes(input logic [15:0] hdr, input int first,
                                     input int count, input bit corners);
        int          pos;
        int          p;
        logic [15:0] pix;
        logic [7:0]  b;
        for (pos = first; pos < first + count; pos++) begin
            if (pos == 0) begin
                b = hdr[15:8];
            end else if (pos == 1) begin
                b = hdr[7:0];
            end else if (pos < HEADER_BYTES) begin
                b = 8'($urandom);
            end else begin
                p   = (pos - HEADER_BYTES) / 2;
                pix = 16'($urandom);
                if (corners) begin
                    case (p)
                        0: pix = 16'hFFFF;
                        1: pix = 16'hC001;
                        2: pix = 16'h0000;
                        3: pix = 16'h3FFF;
                        default: ;
                    endcase
                end
                b = ((pos - HEADER_BYTES) % 2 == 0) ? pix[15:8] : pix[7:0];
            end
            send_beat(REQ_DATA, b);
        end
    endtask

    task automatic send_packet(input logic [15:0] hdr, input bit corners);
        send_packet_bytes(hdr, 0, PKT_BYTES, corners);
    endtask

    // line number in the low 12 bits; the spare top nibble is random
    function automatic logic [15:0] line_header(input int line);
        logic [3:0] spare;
        spare = 4'($urandom);
        return {spare, 12'(line)};
    endfunction

    function automatic logic [15:0] discard_header();
        logic [3:0] spare;
        spare = 4'($urandom);
        return {spare, NIBBLE_MASK, 8'($urandom)};
    endfunction

    // Stop sending, let every owed beat come back, then a few quiet cycles
    // for bytes that produce nothing.
    task automatic settle_outputs();
        s_tvalid <= 1'b0;
        while (pixel_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write; only called with the input quiet and no result owed.
    task automatic write_reg(input logic idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == CFG_LINEAR) cfg_linear = val[0];
        else cfg_limit = val;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, or one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (holdoff_request > 0) begin
            stall_left      = holdoff_request;
            holdoff_request = 0;
        end else if (stall_left == 0 && rx_stalls) begin
            stall_left = idle_gap();
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result check, field by field against the oldest owed beat
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pixel_results_due.size() == 0) begin
                $error("result beat with no result owed");
                errors++;
            end else begin
                due = pixel_results_due.pop_front();
                check_field("pixel_write", 16'(due.pixel_write), 16'(m_tuser));
                check_field("pixel_address", 16'(due.pixel_address), 16'(m_tdata[12:0]));
                check_field("pixel_value", due.pixel_value, m_tdata[28:13]);
                check_field("packet_end", 16'(due.packet_end), 16'(m_tlast));
                check_field("frame_status", 16'(due.frame_status), 16'(m_tdata[30:29]));
                check_field("lines_received", 16'(due.lines_received),
                            16'(m_tdata[36:31]));
                check_field("discarded_packets", due.discarded_packets, m_tdata[52:37]);
            end
        end
    end

    // Watchdog: any beat, register write or reset resets the count.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || i_cfg_we || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // No capture running yet: data bytes vanish.
    task automatic test_bytes_before_begin();
        repeat (6) send_beat(REQ_DATA, 8'($urandom));
        settle_outputs();
    endtask

    // Header decode on packet starts; each later restart also cuts the packet before it short.
    task automatic test_packet_kinds();
        send_beat(REQ_BEGIN, 8'hFF);
        send_packet_bytes(16'hF000, 0, HEADER_BYTES + 8, 1'b1);  // low nibble clear: line 0
        send_beat(REQ_BEGIN, 8'h00);      // restart while mid-packet
        send_packet_bytes(16'h003B, 0, HEADER_BYTES + 2, 1'b1);  // last valid line
        send_beat(REQ_BEGIN, 8'($urandom));
        send_packet_bytes(16'h0F00, 0, HEADER_BYTES + 4, 1'b0);  // discard marker
        send_beat(REQ_BEGIN, 8'($urandom));
        send_packet_bytes(16'hFF3C, 0, HEADER_BYTES + 4, 1'b0);  // discard, all-ones byte
        send_beat(REQ_BEGIN, 8'($urandom));
        send_packet_bytes(16'h003C, 0, HEADER_BYTES + 4, 1'b0);  // first line past the frame
        send_beat(REQ_BEGIN, 8'($urandom));
        send_packet_bytes(16'hEEFF, 0, HEADER_BYTES + 4, 1'b0);  // largest non-discard line
        settle_outputs();
    endtask

    // Mode is taken at each pixel's low byte: flip it between the two halves.
    task automatic test_mode_change();
        logic [15:0] hdr;
        send_beat(REQ_BEGIN, 8'($urandom));
        hdr = line_header(7);
        send_packet_bytes(hdr, 0, HEADER_BYTES + 3, 1'b1);
        settle_outputs();
        write_reg(CFG_LINEAR, 16'h0001);
        send_packet_bytes(hdr, HEADER_BYTES + 3, 3, 1'b1);
        send_beat(REQ_BEGIN, 8'($urandom));
        hdr = line_header(8);
        send_packet_bytes(hdr, 0, HEADER_BYTES + 1, 1'b1);
        settle_outputs();
        write_reg(CFG_LINEAR, 16'h0000);
        send_packet_bytes(hdr, HEADER_BYTES + 1, 3, 1'b1);
        settle_outputs();
    endtask

    // Whole packets: counters, seen lines, discards and the timeout.
    task automatic test_packet_limit();
        write_reg(CFG_LIMIT, 16'd0);                   // out of range, first packet ends it
        send_beat(REQ_BEGIN, 8'($urandom));
        send_packet(line_header(3), 1'b1);
        repeat (8) send_beat(REQ_DATA, 8'($urandom));  // ignored once timed out
        settle_outputs();
        write_reg(CFG_LIMIT, 16'd2);
        send_beat(REQ_BEGIN, 8'($urandom));
        send_packet(discard_header(), 1'b0);           // counted, capture goes on
        settle_outputs();
    endtask

    // Receiver holds off for a long while; sender keeps going until the
    // result queue fills and s_tready drops.
    task automatic test_backpressure();
        tx_gaps         = 1'b0;
        rx_stalls       = 1'b0;
        holdoff_request = HOLDOFF_CYCLES;
        send_beat(REQ_BEGIN, 8'($urandom));
        send_packet_bytes(line_header($urandom_range(0, FRAME_LINES - 1)), 0,
                          HEADER_BYTES + 32, 1'b0);
        settle_outputs();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    // Short random packet starts: valid lines, discards, stray lines and loose
    // bytes, with a new mode now and then between captures.
    task automatic test_random_packets();
        int          i;
        int          pick;
        logic [15:0] hdr;
        send_beat(REQ_BEGIN, 8'($urandom));
        for (i = 0; i < RANDOM_PACKETS; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                settle_outputs();
                write_reg(CFG_LINEAR, 16'($urandom));
                send_beat(REQ_BEGIN, 8'($urandom));
            end
            pick = $urandom_range(0, 99);
            if (pick < 50)
                hdr = line_header($urandom_range(0, FRAME_LINES - 1));
            else if (pick < 70)
                hdr = discard_header();
            else
                hdr = line_header($urandom_range(FRAME_LINES, 12'hEFF));
            if (pick < 85) begin
                send_packet_bytes(hdr, 0, $urandom_range(1, 20), 1'b0);
            end else begin
                repeat ($urandom_range(1, 6)) send_beat(REQ_DATA, 8'($urandom));
            end
            send_beat(REQ_BEGIN, 8'($urandom));
        end
        settle_outputs();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_bytes_before_begin();
        test_packet_kinds();
        test_mode_change();
        test_packet_limit();
        test_backpressure();
        test_random_packets();
        settle_outputs();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> video_packet_frame_assembler.f
rtl/core/vpfa_pkg.sv
rtl/core/vpfa_parser.sv
rtl/core/vpfa_tracker.sv
rtl/core/vpfa_queue.sv
rtl/core/video_packet_frame_assembler.sv
tb/video_packet_frame_assembler_test.sv
